// File: design/ggl_pkg.sv
`default_nettype none
package ggl_pkg;

  // field widths
  localparam int CELL_W  = 24;
  localparam int OWNER_W = 6;
  localparam int CFG_W   = 7;
  localparam int LOAD_W  = 34;
  localparam int GIDX_W  = 10;
  localparam int PROC_W  = 6;

  // stream packing
  localparam int IN_TDATA_W  = 32;
  localparam int IN_PAD_W    = IN_TDATA_W - CELL_W - OWNER_W;
  localparam int OUT_TDATA_W = 96;
  localparam int OUT_USED_W  = GIDX_W + 2 * PROC_W + 2 * LOAD_W + 2;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  // default sizes
  localparam int DEF_MAX_GRIDS = 1024;
  localparam int DEF_MAX_PROCS = 64;
  localparam int DEF_MAX_MOVES = 63;

  // result kinds (carried on tuser)
  localparam logic KIND_MOVE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

  // control of the per-processor load store
  typedef struct packed {
    logic wr_en;
    logic clr;
  } ld_ctl_t;

  function automatic logic [LOAD_W-1:0] sat_add(input logic [LOAD_W-1:0] a,
                                                 input logic [CELL_W-1:0] b);
    logic [LOAD_W:0] s;
    s = {1'b0, a} + (LOAD_W + 1)'(b);
    return s[LOAD_W] ? LOAD_MAX : s[LOAD_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: design/ggl_load_store.sv
`default_nettype none
module ggl_load_store #(
  parameter int NPROC = ggl_pkg::DEF_MAX_PROCS,
  parameter int AW    = 6
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ggl_pkg::ld_ctl_t          ctl,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [ggl_pkg::LOAD_W-1:0] wr_data,
  input  wire logic [AW-1:0]             rd_addr,
  output logic [ggl_pkg::LOAD_W-1:0]     rd_data
);
  import ggl_pkg::*;

  logic [LOAD_W-1:0] mem [NPROC];
  logic [NPROC-1:0]  vld;
  logic [LOAD_W-1:0] data_q;
  logic              vld_q;

  // entries not written this set read as zero
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      vld <= '0;
    end else if (ctl.wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    data_q <= mem[rd_addr];
    vld_q  <= vld[rd_addr];
  end

  assign rd_data = vld_q ? data_q : '0;

endmodule
`default_nettype wire

// File: design/greedy_grid_load_balancer.sv
`default_nettype none
// Greedy grid load balancer.
// A record is accepted, then its processor's load is read, added to and written back
// through the load store. After the last record, each balancing pass scans the loads,
// tests the ratio, searches the grid store, emits a move and writes both loads back;
// once a pass makes no move, the summary follows.
// Reset: procs_in_use returns to 1, loads, grid count, flags and handshakes clear at once;
// the grid store itself is not cleared.
module greedy_grid_load_balancer #(
  parameter int MAX_GRIDS = ggl_pkg::DEF_MAX_GRIDS,
  parameter int MAX_PROCS = ggl_pkg::DEF_MAX_PROCS,
  parameter int MAX_MOVES = ggl_pkg::DEF_MAX_MOVES
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration: procs_in_use
  input  wire logic                           cfg_wr_en,
  input  wire logic [ggl_pkg::CFG_W-1:0]      cfg_wr_data,
  // grid records
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [ggl_pkg::IN_TDATA_W-1:0] s_tdata,   // cell_count, owner_proc, pad
  input  wire logic                           s_tlast,   // last_grid
  // results
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [ggl_pkg::OUT_TDATA_W-1:0]     m_tdata,   // grid_index, from_proc, to_proc,
                                                         // max_load, min_load, move_capped,
                                                         // grids_dropped, pad
  output logic                                m_tuser,   // kind
  output logic                                m_tlast    // last_result
);
  import ggl_pkg::*;

  localparam int GW  = (MAX_GRIDS > 1) ? $clog2(MAX_GRIDS) : 1;  // grid address
  localparam int CW  = $clog2(MAX_GRIDS + 1);                     // grid count
  localparam int PW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;  // processor index
  localparam int PCW = $clog2(MAX_PROCS + 1);                     // processor count
  localparam int OSW = (PW > OWNER_W) ? PW : OWNER_W;             // stored owner
  localparam int MVW = $clog2(MAX_MOVES + 1);
  localparam int MW  = LOAD_W + 5;                                // load times 21

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_ACC    = 11'b00000000010,
    ST_SCAN   = 11'b00000000100,
    ST_SCANW  = 11'b00000001000,
    ST_RATIO  = 11'b00000010000,
    ST_DECIDE = 11'b00000100000,
    ST_GSCAN  = 11'b00001000000,
    ST_EMIT   = 11'b00010000000,
    ST_WR_HI  = 11'b00100000000,
    ST_WR_LO  = 11'b01000000000,
    ST_SUMM   = 11'b10000000000
  } state_t;

  state_t state;

  // configuration and set state
  logic [CFG_W-1:0]  procs_in_use;
  logic [PCW-1:0]    p_eff;
  logic [CW-1:0]     count;
  logic              overflow;
  logic [MVW-1:0]    moves;
  logic              capped;

  // record being accumulated
  logic [CELL_W-1:0] cell_r;
  logic [PW-1:0]     own_r;
  logic              last_r;
  logic              add_en;

  // load scan
  logic [PW-1:0]     scan_i;
  logic              pipe_vld;
  logic [PW-1:0]     pipe_idx;
  logic [PW-1:0]     hi;
  logic [PW-1:0]     lo;
  logic [LOAD_W-1:0] hival;
  logic [LOAD_W-1:0] loval;
  logic [MW-1:0]     m20;
  logic [MW-1:0]     m21;
  logic [LOAD_W-1:0] diff;

  // grid search
  logic [CW-1:0]     gi;
  logic              g_pv;
  logic [GW-1:0]     g_pidx;
  logic [GW-1:0]     g_sel;
  logic [CELL_W-1:0] g_work;

  // grid store
  logic [CELL_W-1:0] grid_work  [MAX_GRIDS];
  logic [OSW-1:0]    grid_owner [MAX_GRIDS];
  logic [CELL_W-1:0] gw_rd;
  logic [OSW-1:0]    go_rd;
  logic              gw_we;
  logic              go_we;
  logic [GW-1:0]     gwa;
  logic [OSW-1:0]    go_wd;

  // load store port
  ld_ctl_t           ld_ctl;
  logic [PW-1:0]     ld_wa;
  logic [LOAD_W-1:0] ld_wd;
  logic [PW-1:0]     ld_ra;
  logic [LOAD_W-1:0] ld_rd;

  logic [CELL_W-1:0]  in_cells;
  logic [OWNER_W-1:0] in_owner;
  logic               s_acc;
  logic               store_ok;
  logic               owner_in_use;
  logic               out_free;
  logic               scan_last;
  logic               g_hit;
  logic               g_last;
  logic               g_issue;
  logic               emit_now;
  logic               moves_done;
  logic               may_balance;

  assign in_cells = s_tdata[CELL_W-1:0];
  assign in_owner = s_tdata[CELL_W +: OWNER_W];

  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // a count of zero acts as one, anything above the limit as the limit
  always_comb begin
    if (procs_in_use == '0) begin
      p_eff = PCW'(1);
    end else if (32'(procs_in_use) > MAX_PROCS) begin
      p_eff = PCW'(MAX_PROCS);
    end else begin
      p_eff = PCW'(procs_in_use);
    end
  end

  assign store_ok     = (32'(count) < MAX_GRIDS);
  assign owner_in_use = (32'(in_owner) < 32'(p_eff));
  assign scan_last    = (32'(scan_i) == 32'(p_eff) - 32'd1);
  assign g_hit        = (go_rd == OSW'(hi)) && ((LOAD_W)'({gw_rd, 1'b0}) < diff);
  assign g_last       = ((CW'(g_pidx) + CW'(1)) == count);
  assign moves_done   = (32'(moves) >= MAX_MOVES);
  assign may_balance  = (32'(p_eff) > 32'd1) && (32'(count) > 32'd1);

  // next grid read is issued while the search neither hits nor ends
  assign g_issue  = (state == ST_GSCAN) && !(g_pv && (g_hit || g_last)) && (gi < count);
  // a move or the summary is loaded into the output register
  assign emit_now = ((state == ST_EMIT) || (state == ST_SUMM)) && out_free;

  // grid store: written on load and on the owner update of a move
  assign gw_we = s_acc && store_ok;
  assign go_we = gw_we || (state == ST_WR_HI);
  assign gwa   = (state == ST_WR_HI) ? g_sel : count[GW-1:0];
  assign go_wd = (state == ST_WR_HI) ? OSW'(lo) : OSW'(in_owner);

  always_ff @(posedge clk) begin
    if (gw_we) begin
      grid_work[gwa] <= in_cells;
    end
    if (go_we) begin
      grid_owner[gwa] <= go_wd;
    end
    gw_rd <= grid_work[gi[GW-1:0]];
    go_rd <= grid_owner[gi[GW-1:0]];
  end

  // load store: one write a cycle, shared by accumulate and both halves of a move
  always_comb begin
    ld_ctl.wr_en = ((state == ST_ACC) && add_en) || (state == ST_WR_HI) ||
                   (state == ST_WR_LO);
    ld_ctl.clr   = (state == ST_SUMM) && out_free;
    ld_ra        = (state == ST_IDLE) ? PW'(in_owner) : scan_i;
    unique case (state)
      ST_ACC: begin
        ld_wa = own_r;
        ld_wd = sat_add(ld_rd, cell_r);
      end
      ST_WR_HI: begin
        ld_wa = hi;
        ld_wd = hival - LOAD_W'(g_work);
      end
      default: begin
        ld_wa = lo;
        ld_wd = sat_add(loval, g_work);
      end
    endcase
  end

  ggl_load_store #(
    .NPROC (MAX_PROCS),
    .AW    (PW)
  ) u_load (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ld_ctl),
    .wr_addr (ld_wa),
    .wr_data (ld_wd),
    .rd_addr (ld_ra),
    .rd_data (ld_rd)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      procs_in_use <= CFG_W'(1);
      count        <= '0;
      overflow     <= 1'b0;
      moves        <= '0;
      capped       <= 1'b0;
      pipe_vld     <= 1'b0;
      g_pv         <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        procs_in_use <= cfg_wr_data;
      end
      // held until taken, reloaded when a result goes out
      m_tvalid <= emit_now || (m_tvalid && !m_tready);

      // running max/min over the loads; ties keep the lower index
      if (pipe_vld) begin
        if (pipe_idx == '0) begin
          hi    <= '0;
          lo    <= '0;
          hival <= ld_rd;
          loval <= ld_rd;
        end else begin
          if (ld_rd > hival) begin
            hi    <= pipe_idx;
            hival <= ld_rd;
          end
          if (ld_rd < loval) begin
            lo    <= pipe_idx;
            loval <= ld_rd;
          end
        end
      end

      pipe_vld <= (state == ST_SCAN);
      g_pv     <= g_issue;

      unique case (state)
        ST_IDLE: begin
          if (s_acc) begin
            cell_r <= in_cells;
            own_r  <= PW'(in_owner);
            last_r <= s_tlast;
            add_en <= store_ok && owner_in_use;
            if (store_ok) begin
              count <= count + CW'(1);
            end else begin
              overflow <= 1'b1;
            end
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          scan_i <= '0;
          state  <= last_r ? ST_SCAN : ST_IDLE;
        end
        ST_SCAN: begin
          pipe_idx <= scan_i;
          if (scan_last) begin
            state <= ST_SCANW;
          end else begin
            scan_i <= scan_i + PW'(1);
          end
        end
        ST_SCANW: begin
          state <= ST_RATIO;
        end
        ST_RATIO: begin
          // 20*max against 21*min, as shifts and adds
          m20   <= (MW'(hival) << 4) + (MW'(hival) << 2);
          m21   <= (MW'(loval) << 4) + (MW'(loval) << 2) + MW'(loval);
          diff  <= hival - loval;
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          gi <= '0;
          if (may_balance && (m20 > m21)) begin
            state <= ST_GSCAN;
          end else begin
            state <= ST_SUMM;
          end
        end
        ST_GSCAN: begin
          if (g_pv && g_hit) begin
            if (moves_done) begin
              capped <= 1'b1;
              state  <= ST_SUMM;
            end else begin
              g_sel  <= g_pidx;
              g_work <= gw_rd;
              state  <= ST_EMIT;
            end
          end else if (g_pv && g_last) begin
            state <= ST_SUMM;
          end else if (gi < count) begin
            g_pidx <= gi[GW-1:0];
            gi     <= gi + CW'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tuser  <= KIND_MOVE;
            m_tlast  <= 1'b0;
            m_tdata  <= {{OUT_PAD_W{1'b0}}, overflow, 1'b0, {LOAD_W{1'b0}},
                         {LOAD_W{1'b0}}, PROC_W'(lo), PROC_W'(hi), GIDX_W'(g_sel)};
            state    <= ST_WR_HI;
          end
        end
        ST_WR_HI: begin
          state <= ST_WR_LO;
        end
        ST_WR_LO: begin
          moves  <= moves + MVW'(1);
          scan_i <= '0;
          state  <= ST_SCAN;
        end
        ST_SUMM: begin
          if (out_free) begin
            m_tuser  <= KIND_SUMMARY;
            m_tlast  <= 1'b1;
            m_tdata  <= {{OUT_PAD_W{1'b0}}, overflow, capped, loval, hival,
                         PROC_W'(lo), PROC_W'(hi), {GIDX_W{1'b0}}};
            count    <= '0;
            overflow <= 1'b0;
            moves    <= '0;
            capped   <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/ggl_checker.sv
`default_nettype none
module ggl_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [ggl_pkg::OUT_TDATA_W-1:0] m_tdata,
  input wire logic                           m_tuser,
  input wire logic                           m_tlast
);
  import ggl_pkg::*;

  // records are taken one at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken on consecutive cycles");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("result changed under stall");

  // only the summary closes a run
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == KIND_SUMMARY)))
    else $error("last flag does not match result kind");

  // a move never goes back to its own processor
  a_move_procs: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_MOVE)) |->
      (m_tdata[GIDX_W +: PROC_W] != m_tdata[GIDX_W + PROC_W +: PROC_W]))
    else $error("move with equal source and destination");

endmodule

bind greedy_grid_load_balancer ggl_checker u_ggl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire

// File: verif/greedy_grid_load_balancer_test.sv
`timescale 1ns / 1ps
module greedy_grid_load_balancer_test;
  import ggl_pkg::*;

  localparam int GRID_SLOTS  = DEF_MAX_GRIDS;
  localparam int PROC_SLOTS  = DEF_MAX_PROCS;
  localparam int MOVE_LIMIT  = DEF_MAX_MOVES;
  localparam int SETTLE      = 8;      // settle margin after a drain
  localparam int HOLD_OFF    = 400;    // long receiver hold-off
  localparam int QUIET_LIMIT = 20000;  // cycles with no transfer on either side
  localparam int CAP_GRIDS   = 70;     // enough unit grids to outlast the move limit
  localparam int RANDOM_ITEMS = 30;

  // One result of the block, as the balancer works it out.
  typedef struct packed {
    logic              kind;
    logic [GIDX_W-1:0] grid;
    logic [PROC_W-1:0] src;
    logic [PROC_W-1:0] dst;
    logic [LOAD_W-1:0] hi_load;
    logic [LOAD_W-1:0] lo_load;
    logic              capped;
    logic              dropped;
    logic              fin;
  } outcome_t;

  // Result tdata layout, lowest bit last in this list.
  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic                 dropped;
    logic                 capped;
    logic [LOAD_W-1:0]    lo_load;
    logic [LOAD_W-1:0]    hi_load;
    logic [PROC_W-1:0]    dst;
    logic [PROC_W-1:0]    src;
    logic [GIDX_W-1:0]    grid;
  } result_word_t;

  // Directed stimulus row; 'typed' rows carry an expectation written by hand.
  typedef struct {
    bit               set_cfg;
    logic [CFG_W-1:0] cfg;
    logic [CELL_W-1:0] cells;
    logic [OWNER_W-1:0] owner;
    bit               last;
    bit               typed;
    outcome_t         want;
  } grid_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_W-1:0]       cfg_wr_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;    // cell_count, owner_proc, pad
  logic                   s_tlast;    // last_grid
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;    // grid_index, from_proc, to_proc, max_load,
                                      // min_load, move_capped, grids_dropped, pad
  logic                   m_tuser;    // kind
  logic                   m_tlast;    // last_result

  greedy_grid_load_balancer DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  // ---------------------------------------------------------------------------
  // Balancer state as the testbench tracks it.
  // ---------------------------------------------------------------------------
  logic [CELL_W-1:0]  bal_work  [GRID_SLOTS];
  logic [OWNER_W-1:0] bal_owner [GRID_SLOTS];
  logic [LOAD_W-1:0]  bal_load  [PROC_SLOTS];
  int unsigned        bal_count;
  bit                 bal_dropped;
  logic [CFG_W-1:0]   bal_procs;

  outcome_t  balance_log[$];   // moves and summaries still owed by the block
  grid_row_t grid_table[$];

  int  fails;
  int  records_sent;
  bit  gaps_on;       // random idling on both sides
  bit  hold_req;      // asks the receiver for one long hold-off

  // Register value as the block applies it: 0 acts as 1, above 64 as 64.
  function automatic int procs_active();
    if (bal_procs == 0) return 1;
    if (bal_procs > PROC_SLOTS) return PROC_SLOTS;
    return int'(bal_procs);
  endfunction

  function automatic logic [LOAD_W-1:0] add_capped(input logic [LOAD_W-1:0] a,
                                                   input logic [CELL_W-1:0] b);
    logic [LOAD_W:0] s;
    s = {1'b0, a} + (LOAD_W + 1)'(b);
    return s[LOAD_W] ? {LOAD_W{1'b1}} : s[LOAD_W-1:0];
  endfunction

  // Most and least loaded processors; ties go to the lowest index.
  task automatic scan_extremes(input int p, output int hi, output int lo);
    hi = 0;
    lo = 0;
    for (int i = 1; i < p; i++) begin
      if (bal_load[i] > bal_load[hi]) hi = i;
      if (bal_load[i] < bal_load[lo]) lo = i;
    end
  endtask

  // Takes one accepted record; on the last of a set, runs the greedy passes and
  // queues every move and the summary.
  task automatic load_grid(input logic [CELL_W-1:0] cells, input logic [OWNER_W-1:0] owner,
                           input bit last);
    int p, hi, lo, g, moves;
    bit capped;
    logic [LOAD_W-1:0] mx, mn;
    logic [LOAD_W+5:0] lhs, rhs;
    outcome_t r;
    p = procs_active();
    if (bal_count < GRID_SLOTS) begin
      bal_work[bal_count]  = cells;
      bal_owner[bal_count] = owner;
      bal_count++;
      if (owner < p) bal_load[owner] = add_capped(bal_load[owner], cells);
    end else begin
      bal_dropped = 1'b1;
    end
    if (!last) return;

    scan_extremes(p, hi, lo);
    capped = 1'b0;
    moves = 0;
    if (p > 1 && bal_count > 1) begin
      while (1) begin
        mx = bal_load[hi];
        mn = bal_load[lo];
        // ratio 1.05 as 20*max > 21*min
        lhs = (LOAD_W + 6)'(mx) * 20;
        rhs = (LOAD_W + 6)'(mn) * 21;
        if (lhs <= rhs) break;
        // first grid on the busiest processor under half the gap
        g = 0;
        while (g < int'(bal_count) &&
               !(bal_owner[g] == hi && {bal_work[g], 1'b0} < {1'b0, mx - mn}))
          g++;
        if (g == int'(bal_count)) break;
        if (moves >= MOVE_LIMIT) begin
          capped = 1'b1;
          break;
        end
        bal_owner[g] = OWNER_W'(lo);
        bal_load[hi] = mx - bal_work[g];
        bal_load[lo] = add_capped(mn, bal_work[g]);
        r = '0;
        r.kind    = KIND_MOVE;
        r.grid    = GIDX_W'(g);
        r.src     = PROC_W'(hi);
        r.dst     = PROC_W'(lo);
        r.dropped = bal_dropped;
        balance_log.push_back(r);
        scan_extremes(p, hi, lo);
        moves++;
      end
    end

    r = '0;
    r.kind    = KIND_SUMMARY;
    r.src     = PROC_W'(hi);
    r.dst     = PROC_W'(lo);
    r.hi_load = bal_load[hi];
    r.lo_load = bal_load[lo];
    r.capped  = capped;
    r.dropped = bal_dropped;
    r.fin     = 1'b1;
    balance_log.push_back(r);

    for (int i = 0; i < PROC_SLOTS; i++) bal_load[i] = '0;
    bal_count   = 0;
    bal_dropped = 1'b0;
  endtask

  function automatic outcome_t summary_of(input int src, input int dst,
                                          input logic [LOAD_W-1:0] hi,
                                          input logic [LOAD_W-1:0] lo);
    outcome_t r;
    r = '0;
    r.kind    = KIND_SUMMARY;
    r.src     = PROC_W'(src);
    r.dst     = PROC_W'(dst);
    r.hi_load = hi;
    r.lo_load = lo;
    r.fin     = 1'b1;
    return r;
  endfunction

  task automatic add_row(input bit set_cfg, input logic [CFG_W-1:0] cfg,
                         input logic [CELL_W-1:0] cells, input logic [OWNER_W-1:0] owner,
                         input bit last, input bit typed = 1'b0, input outcome_t want = '0);
    grid_row_t row;
    row.set_cfg = set_cfg;
    row.cfg     = cfg;
    row.cells   = cells;
    row.owner   = owner;
    row.last    = last;
    row.typed   = typed;
    row.want    = want;
    grid_table.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Sender side. All inputs change on the falling edge; one assignment per
  // signal per edge, so a valid kept high for the next record is never dropped.
  // ---------------------------------------------------------------------------
  task automatic offer_grid(input logic [CELL_W-1:0] cells, input logic [OWNER_W-1:0] owner,
                            input bit last, input bit typed = 1'b0,
                            input outcome_t want = '0);
    int n0;
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 18) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {{IN_PAD_W{1'b0}}, owner, cells};
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
    // transfer taken at this edge
    n0 = balance_log.size();
    load_grid(cells, owner, last);
    if (typed) begin
      while (balance_log.size() > n0) balance_log.delete(balance_log.size() - 1);
      balance_log.push_back(want);
    end
    records_sent++;
  endtask

  // Sender pauses until every owed result has come, then lets the block settle.
  task automatic drain(input int settle);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (balance_log.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_procs(input logic [CFG_W-1:0] value);
    drain(SETTLE);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    bal_procs   = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_procs();
    case ($urandom_range(7))
      0: return CFG_W'($urandom_range(127));
      1: case ($urandom_range(4))
           0: return 7'd0;
           1: return 7'd1;
           2: return 7'd64;
           3: return 7'd65;
           default: return 7'd127;
         endcase
      default: return CFG_W'($urandom_range(2, 6));
    endcase
  endfunction

  function automatic logic [CELL_W-1:0] pick_cells();
    case ($urandom_range(2))
      0: return CELL_W'($urandom_range(0, 24'hFFFFFF));
      1: return CELL_W'($urandom_range(255));
      default: return CELL_W'($urandom_range(65535));
    endcase
  endfunction

  // Mostly owners in use, now and then any owner at all.
  function automatic logic [OWNER_W-1:0] pick_owner();
    if ($urandom_range(9) == 0) return OWNER_W'($urandom_range(63));
    return OWNER_W'($urandom_range(procs_active() - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side: random ready, one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready = 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
      end
      m_tready = !(gaps_on && $urandom_range(99) < 18);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking at the rising edge.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [LOAD_W-1:0] exp_v,
                             input logic [LOAD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin : result_check
    outcome_t want;
    result_word_t word;
    if (!rst && m_tvalid && m_tready) begin
      word = result_word_t'(m_tdata);
      if (balance_log.size() == 0) begin
        $error("result transfer with nothing owed: kind %0d grid %0d", m_tuser, word.grid);
        fails++;
      end else begin
        want = balance_log.pop_front();
        check_field("kind",          LOAD_W'(want.kind),    LOAD_W'(m_tuser));
        check_field("grid_index",    LOAD_W'(want.grid),    LOAD_W'(word.grid));
        check_field("from_proc",     LOAD_W'(want.src),     LOAD_W'(word.src));
        check_field("to_proc",       LOAD_W'(want.dst),     LOAD_W'(word.dst));
        check_field("max_load",      want.hi_load,          word.hi_load);
        check_field("min_load",      want.lo_load,          word.lo_load);
        check_field("move_capped",   LOAD_W'(want.capped),  LOAD_W'(word.capped));
        check_field("grids_dropped", LOAD_W'(want.dropped), LOAD_W'(word.dropped));
        check_field("last_result",   LOAD_W'(want.fin),     LOAD_W'(m_tlast));
      end
    end
  end

  // Watchdog: ends the run if nothing moves on either side for too long.
  always @(posedge clk) begin : watchdog
    int quiet;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int len, cut, set_no, start;
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tlast      = 1'b0;
    fails        = 0;
    records_sent = 0;
    gaps_on      = 1'b1;
    hold_req     = 1'b0;
    for (int i = 0; i < PROC_SLOTS; i++) bal_load[i] = '0;
    bal_count   = 0;
    bal_dropped = 1'b0;
    bal_procs   = 7'd1;

    // Directed table.
    // one processor after reset: largest cell, nothing to move
    add_row(1'b0, 7'd0, 24'hFFFFFF, 6'd0, 1'b1, 1'b1,
            summary_of(0, 0, 34'hFFFFFF, 34'hFFFFFF));
    // owner not in use: load never counted, all loads zero -> processor 0 twice
    add_row(1'b0, 7'd0, 24'd5, 6'd63, 1'b1, 1'b1, summary_of(0, 0, 34'd0, 34'd0));
    // register value 0 behaves as one processor
    add_row(1'b1, 7'd0, 24'd0, 6'd0, 1'b1, 1'b1, summary_of(0, 0, 34'd0, 34'd0));
    // register above range: 64 processors, one move onto processor 0
    add_row(1'b1, 7'd127, 24'd100, 6'd63, 1'b0);
    add_row(1'b0, 7'd0, 24'd1, 6'd63, 1'b0);
    add_row(1'b0, 7'd0, 24'd0, 6'd0, 1'b1);
    // a single grid: no moves
    add_row(1'b1, 7'd2, 24'd1000, 6'd0, 1'b1, 1'b1, summary_of(0, 1, 34'd1000, 34'd0));
    // several moves among three, one owner not in use
    add_row(1'b1, 7'd3, 24'd800, 6'd0, 1'b0);
    add_row(1'b0, 7'd0, 24'd300, 6'd0, 1'b0);
    add_row(1'b0, 7'd0, 24'd100, 6'd0, 1'b0);
    add_row(1'b0, 7'd0, 24'd999, 6'd5, 1'b0);
    add_row(1'b0, 7'd0, 24'd50, 6'd0, 1'b0);
    add_row(1'b0, 7'd0, 24'd40, 6'd1, 1'b1);
    // ratio exactly 1.05: balanced already
    add_row(1'b1, 7'd2, 24'd21, 6'd0, 1'b0);
    add_row(1'b0, 7'd0, 24'd20, 6'd1, 1'b1, 1'b1, summary_of(0, 1, 34'd21, 34'd20));
    // ratio just above, but no grid small enough
    add_row(1'b0, 7'd0, 24'd22, 6'd0, 1'b0);
    add_row(1'b0, 7'd0, 24'd20, 6'd1, 1'b1, 1'b1, summary_of(0, 1, 34'd22, 34'd20));
    // processor count cut mid-set: load on processor 3 stays out of the scans
    add_row(1'b1, 7'd4, 24'd7, 6'd3, 1'b0);
    add_row(1'b1, 7'd2, 24'd9, 6'd1, 1'b1, 1'b1, summary_of(1, 0, 34'd9, 34'd0));
    // tie on both ends goes to the lowest index
    add_row(1'b1, 7'd4, 24'd7, 6'd1, 1'b0);
    add_row(1'b0, 7'd0, 24'd7, 6'd2, 1'b1, 1'b1, summary_of(1, 0, 34'd7, 34'd0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (grid_table[i]) begin
      if (grid_table[i].set_cfg) write_procs(grid_table[i].cfg);
      offer_grid(grid_table[i].cells, grid_table[i].owner, grid_table[i].last,
                 grid_table[i].typed, grid_table[i].want);
    end

    // Move limit: unit grids all on processor 0 of 64, spread one per processor,
    // so a further move is still due after the limit. No idling at all.
    write_procs(7'd64);
    gaps_on = 1'b0;
    for (int i = 0; i < CAP_GRIDS; i++)
      offer_grid(24'd1, 6'd0, i == CAP_GRIDS - 1);
    drain(SETTLE);
    gaps_on = 1'b1;

    // Random sets. The receiver holds off early on while the sender keeps going,
    // so results back up and the input stalls.
    write_procs(7'd4);
    start  = records_sent;
    set_no = 0;
    while (records_sent - start < RANDOM_ITEMS) begin
      if (set_no >= 3 && $urandom_range(2) == 0) write_procs(pick_procs());
      len = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
      cut = ($urandom_range(7) == 0) ? $urandom_range(1, len) : 0;
      for (int i = 0; i < len; i++) begin
        if (cut != 0 && i == cut && set_no >= 3) write_procs(pick_procs());
        offer_grid(pick_cells(), pick_owner(), i == len - 1);
      end
      if (set_no == 0) hold_req = 1'b1;
      set_no++;
    end

    drain(40);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/ggl_pkg.sv
design/ggl_load_store.sv
design/greedy_grid_load_balancer.sv
design/ggl_checker.sv
verif/greedy_grid_load_balancer_test.sv
